// ----- rtl/vns3d_pkg.sv -----
// Shared types for the 3D vector normalise-and-scale block.
package vns3d_pkg;

  // Classification carried from the front part to the back part.
  typedef struct packed {
    logic zero_len;   // length is zero, pass the vector through
    logic neg_x;
    logic neg_y;
    logic neg_z;
    logic neg_t;
  } vns3d_cls_t;

endpackage

// ----- rtl/vns3d_front.sv -----
// Front part: takes magnitudes and signs, squares and sums, then a pipelined square root.
module vns3d_front import vns3d_pkg::*; #(
  parameter int unsigned CW = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                in_valid_i,
  input  logic [CW-1:0]       vx_i,
  input  logic [CW-1:0]       vy_i,
  input  logic [CW-1:0]       vz_i,
  input  logic [CW-1:0]       vt_i,
  output logic                out_valid_o,
  output logic [3*CW-1:0]     raw_o,
  output logic [4*CW-1:0]     mag_o,
  output logic [CW:0]         len_o,
  output vns3d_cls_t          cls_o
);

  // Sum of three squares stays below 2^(2*CW), so the root fits CW bits; one spare bit kept.
  localparam int unsigned RW = CW + 1;
  localparam int unsigned SW = 2 * RW;
  localparam int unsigned NS = RW + 2;

  logic [NS-1:0]        vld_q;
  logic [3*CW-1:0]      raw_q [NS];
  logic [4*CW-1:0]      mag_q [NS];
  logic [4:0]           neg_q [NS];
  logic [SW-1:0]        rem_q [2:NS-1];
  logic [SW-1:0]        sum_q;
  logic [RW-1:0]        root_q [2:NS-1];
  logic [2*CW-1:0]      sq_q [3];
  logic [CW-1:0]        mag_d [4];
  logic [4:0]           neg_d;

  always_comb begin
    neg_d = {vt_i[CW-1], vz_i[CW-1], vy_i[CW-1], vx_i[CW-1], 1'b0};
    mag_d[0] = vx_i[CW-1] ? CW'(-vx_i) : vx_i;
    mag_d[1] = vy_i[CW-1] ? CW'(-vy_i) : vy_i;
    mag_d[2] = vz_i[CW-1] ? CW'(-vz_i) : vz_i;
    mag_d[3] = vt_i[CW-1] ? CW'(-vt_i) : vt_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NS-2:0], in_valid_i};
    end
  end

  // Stage 0: magnitudes and squares; stage 1: sum; stage 2: root start; then one bit a stage.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      raw_q[0] <= {vz_i, vy_i, vx_i};
      mag_q[0] <= {mag_d[3], mag_d[2], mag_d[1], mag_d[0]};
      neg_q[0] <= neg_d;
      sq_q[0]  <= (2*CW)'(mag_d[0]) * (2*CW)'(mag_d[0]);
      sq_q[1]  <= (2*CW)'(mag_d[1]) * (2*CW)'(mag_d[1]);
      sq_q[2]  <= (2*CW)'(mag_d[2]) * (2*CW)'(mag_d[2]);
      raw_q[1] <= raw_q[0];
      mag_q[1] <= mag_q[0];
      neg_q[1] <= neg_q[0];
      sum_q    <= SW'(sq_q[0]) + SW'(sq_q[1]) + SW'(sq_q[2]);
      raw_q[2] <= raw_q[1];
      mag_q[2] <= mag_q[1];
      neg_q[2] <= neg_q[1];
      rem_q[2] <= sum_q;
      root_q[2] <= '0;
      for (int s = 3; s < NS; s++) begin
        raw_q[s] <= raw_q[s-1];
        mag_q[s] <= mag_q[s-1];
        neg_q[s] <= neg_q[s-1];
      end
    end
  end

  // Restoring root, bit b decided in stage NS-1-b.
  for (genvar s = 3; s < NS; s++) begin : g_sqrt
    localparam int unsigned B = NS - 1 - s;
    logic [SW-1:0] trial;
    always_comb trial = (SW'(root_q[s-1]) << (B + 1)) | (SW'(1) << (2 * B));
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (rem_q[s-1] >= trial) begin
          rem_q[s]  <= rem_q[s-1] - trial;
          root_q[s] <= root_q[s-1] | (RW'(1) << B);
        end else begin
          rem_q[s]  <= rem_q[s-1];
          root_q[s] <= root_q[s-1];
        end
      end
    end
  end

  assign out_valid_o = vld_q[NS-1];
  assign raw_o       = raw_q[NS-1];
  assign mag_o       = mag_q[NS-1];
  assign len_o       = root_q[NS-1];
  always_comb begin
    cls_o.zero_len = (root_q[NS-1] == '0);
    cls_o.neg_x    = neg_q[NS-1][1];
    cls_o.neg_y    = neg_q[NS-1][2];
    cls_o.neg_z    = neg_q[NS-1][3];
    cls_o.neg_t    = neg_q[NS-1][4];
  end

endmodule

// ----- rtl/vns3d_fifo.sv -----
// Short queue between the front and back parts.
module vns3d_fifo #(
  parameter int unsigned W = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         wr_i,
  input  logic [W-1:0] wdata_i,
  input  logic         rd_i,
  output logic         empty_o,
  output logic         full_o,
  output logic [W-1:0] rdata_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CNTW = $clog2(DEPTH + 1);
  logic [W-1:0]  mem_q [DEPTH];
  logic [AW-1:0] wp_q, rp_q;
  logic [CNTW-1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (wr_i) wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + AW'(1);
      if (rd_i) rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + AW'(1);
      if (wr_i && !rd_i) cnt_q <= cnt_q + CNTW'(1);
      else if (rd_i && !wr_i) cnt_q <= cnt_q - CNTW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) mem_q[wp_q] <= wdata_i;
  end

  assign rdata_o = mem_q[rp_q];
  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CNTW'(DEPTH));

endmodule

// ----- rtl/vns3d_back.sv -----
// Back part: pipelined products and restoring division per component, with output register.
module vns3d_back import vns3d_pkg::*; #(
  parameter int unsigned CW = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            in_valid_i,
  input  logic [3*CW-1:0] raw_i,
  input  logic [4*CW-1:0] mag_i,
  input  logic [CW:0]     len_i,
  input  vns3d_cls_t      cls_i,
  output logic            out_valid_o,
  output logic [3*CW-1:0] res_o,
  output logic            zero_o
);

  localparam int unsigned PW = 2 * CW;   // product width
  localparam int unsigned LW = CW + 1;   // divisor width
  localparam int unsigned NS = PW + 2;   // product stage, PW division stages, sign stage

  logic [NS-1:0]    vld_q;
  logic [3*CW-1:0]  raw_q [NS];
  logic [LW-1:0]    len_q [NS];
  vns3d_cls_t       cls_q [NS];
  logic [PW-1:0]    num_q [3][PW+1];
  logic [LW:0]      rem_q [3][PW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (en_i) vld_q <= {vld_q[NS-2:0], in_valid_i};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      raw_q[0] <= raw_i;
      len_q[0] <= len_i;
      cls_q[0] <= cls_i;
      for (int k = 0; k < 3; k++) begin
        num_q[k][0] <= PW'(mag_i[k*CW +: CW]) * PW'(mag_i[3*CW +: CW]);
        rem_q[k][0] <= '0;
      end
      for (int s = 1; s < NS; s++) begin
        raw_q[s] <= raw_q[s-1];
        len_q[s] <= len_q[s-1];
        cls_q[s] <= cls_q[s-1];
      end
    end
  end

  // One quotient bit a stage; the numerator register shifts quotient bits in at the bottom.
  for (genvar k = 0; k < 3; k++) begin : g_lane
    for (genvar s = 1; s <= PW; s++) begin : g_div
      logic [LW:0] sh;
      always_comb sh = {rem_q[k][s-1][LW-1:0], num_q[k][s-1][PW-1]};
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          if (sh >= {1'b0, len_q[s-1]}) begin
            rem_q[k][s] <= sh - {1'b0, len_q[s-1]};
            num_q[k][s] <= {num_q[k][s-1][PW-2:0], 1'b1};
          end else begin
            rem_q[k][s] <= sh;
            num_q[k][s] <= {num_q[k][s-1][PW-2:0], 1'b0};
          end
        end
      end
    end
  end

  // Sign, saturation and pass-through in the final stage, which is the output register.
  logic [3*CW-1:0] res_q;
  logic            zero_q;
  logic [CW-1:0]   r_d [3];
  logic [2:0]      neg_d;

  always_comb begin
    neg_d = {cls_q[NS-2].neg_z, cls_q[NS-2].neg_y, cls_q[NS-2].neg_x};
    for (int k = 0; k < 3; k++) begin
      logic [PW-1:0] q;
      logic          rn;
      q  = num_q[k][NS-2];
      rn = (neg_d[k] != cls_q[NS-2].neg_t) && (q != '0);
      if (rn) begin
        r_d[k] = (q > PW'({1'b1, {(CW-1){1'b0}}})) ? {1'b1, {(CW-1){1'b0}}} : CW'(-q);
      end else begin
        r_d[k] = (q > PW'({1'b0, {(CW-1){1'b1}}})) ? {1'b0, {(CW-1){1'b1}}} : q[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zero_q <= cls_q[NS-2].zero_len;
      res_q  <= cls_q[NS-2].zero_len ? raw_q[NS-2] : {r_d[2], r_d[1], r_d[0]};
    end
  end

  assign out_valid_o = vld_q[NS-1];
  assign res_o       = res_q;
  assign zero_o      = zero_q;

endmodule

// ----- rtl/vector_normalize_scale_3d.sv -----
// Top level: 3D vector normalise-and-scale, streaming in and out.
//
//  channel   dir  tdata fields (low bit up)                 tuser
//  s_axis    in   vec_x, vec_y, vec_z, target_length        -
//  m_axis    out  res_x, res_y, res_z                        zero_length
//
// One request a cycle sustained while m_axis_tready stays high. A taken request passes
// CW+3 front stages (squares, sum, square root), the queue and 2*CW+2 back stages
// (product, divider, sign and output register) before its result is valid.
// Each part stalls as a whole when its output cannot move: the back when its output
// register is held, the front when its last stage is valid and the queue is full.
// Reset clears valid and queue state only.
module vector_normalize_scale_3d import vns3d_pkg::*; #(
  parameter int unsigned COMP_WIDTH = 32,
  // Q format is preserved end to end; the fraction point needs no shift.
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [4*COMP_WIDTH-1:0] s_axis_tdata,  // vec_x, vec_y, vec_z, target_length
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  output logic [3*COMP_WIDTH-1:0] m_axis_tdata,  // res_x, res_y, res_z
  output logic                    m_axis_tuser   // zero_length
);

  localparam int unsigned CW = COMP_WIDTH;
  localparam int unsigned QD = 4;          // queue depth
  localparam int unsigned QW = 3*CW + 4*CW + CW + 1 + $bits(vns3d_cls_t);

  logic f_en, f_vld, f_wr, q_empty, q_full, q_rd;
  logic [3*CW-1:0] f_raw;
  logic [4*CW-1:0] f_mag;
  logic [CW:0]     f_len;
  vns3d_cls_t      f_cls;
  logic [QW-1:0]   q_rdata;

  // Front holds whole while its last stage has a request the full queue cannot take.
  assign f_en = !(f_vld && q_full);
  assign f_wr = f_vld && f_en;
  assign s_axis_tready = f_en;

  vns3d_front #(.CW(CW)) u_front (
    .clk_i, .rst_ni, .en_i(f_en),
    .in_valid_i(s_axis_tvalid && s_axis_tready),
    .vx_i(s_axis_tdata[0 +: CW]), .vy_i(s_axis_tdata[CW +: CW]),
    .vz_i(s_axis_tdata[2*CW +: CW]), .vt_i(s_axis_tdata[3*CW +: CW]),
    .out_valid_o(f_vld), .raw_o(f_raw), .mag_o(f_mag), .len_o(f_len), .cls_o(f_cls)
  );

  vns3d_fifo #(.W(QW), .DEPTH(QD)) u_fifo (
    .clk_i, .rst_ni, .wr_i(f_wr), .wdata_i({f_cls, f_len, f_mag, f_raw}),
    .rd_i(q_rd), .empty_o(q_empty), .full_o(q_full), .rdata_o(q_rdata)
  );

  // Back pipe stalls whole when its output register is full and not taken.
  logic b_en, b_vld;
  logic [3*CW-1:0] b_res;
  logic b_zero;
  assign b_en = !m_axis_tvalid || m_axis_tready;
  assign q_rd = b_en && !q_empty;

  vns3d_back #(.CW(CW)) u_back (
    .clk_i, .rst_ni, .en_i(b_en), .in_valid_i(q_rd),
    .raw_i(q_rdata[0 +: 3*CW]), .mag_i(q_rdata[3*CW +: 4*CW]),
    .len_i(q_rdata[7*CW +: CW+1]),
    .cls_i(vns3d_cls_t'(q_rdata[QW-1 -: $bits(vns3d_cls_t)])),
    .out_valid_o(b_vld), .res_o(b_res), .zero_o(b_zero)
  );

  assign m_axis_tvalid = b_vld;
  assign m_axis_tdata  = b_res;
  assign m_axis_tuser  = b_zero;

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_full && !q_rd |-> !f_wr) else $error("queue overflow");
  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("result dropped");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata)) else $error("result changed");
  a_user_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tuser)) else $error("flag changed");

endmodule
